>>> hw/rtl/sni_pkg.sv
package sni_pkg;

  typedef enum logic [2:0] {
    REG_RADIUS_SQ = 3'd0,
    REG_GAMMA     = 3'd1,
    REG_PERIODIC  = 3'd2,
    REG_PERIOD_X  = 3'd3,
    REG_PERIOD_Y  = 3'd4
  } reg_index_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [16:0] INTENSITY_MAX = 17'd131071;

endpackage

>>> hw/rtl/sni_ram.sv
module sni_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/strauss_neighbour_intensity_core.sv
// Strauss neighbour count and conditional intensity. A write (operation 0) stores one
// point when point_index < MAX_POINTS; busy stays low. A query (operation 1) scans
// slots 0..n-1, n = min(point_count, MAX_POINTS), one point store read per slot, with
// a single shared 17x17 multiplier squaring dx then dy, so each slot passes through
// ST_DIST, ST_SQX, ST_SQY and ST_CMP. gamma^count then takes at most one multiplier
// pass per counted neighbour, ending early at acc == 0 or gamma == 0. done is high
// for exactly one cycle and cannot be held off, so the receiver must take it then.
// The point store is not cleared at reset: read only slots that have been written.
module strauss_neighbour_intensity_core #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [9:0]         point_index,
  input  logic               skip_valid,
  input  logic [10:0]        point_count,
  output logic               done,
  output logic [10:0]        neighbour_count,
  output logic [16:0]        intensity,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int          RAM_AW  = $clog2(MAX_POINTS);
  localparam logic [10:0] CNT_CAP = (MAX_POINTS > 2047) ? 11'd2047 : 11'(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_DIST,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_PINIT,
    ST_POW
  } state_t;

  state_t state;

  // configuration
  logic [33:0] radius_sq;
  logic [16:0] gamma_value;
  logic        periodic_mode;
  logic [15:0] period_x;
  logic [15:0] period_y;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq     <= '0;
      gamma_value   <= sni_pkg::ONE_Q16;
      periodic_mode <= 1'b0;
      period_x      <= '0;
      period_y      <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        sni_pkg::REG_RADIUS_SQ: radius_sq     <= pwdata[33:0];
        sni_pkg::REG_GAMMA:     gamma_value   <= pwdata[16:0];
        sni_pkg::REG_PERIODIC:  periodic_mode <= pwdata[0];
        sni_pkg::REG_PERIOD_X:  period_x      <= pwdata[15:0];
        sni_pkg::REG_PERIOD_Y:  period_y      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      sni_pkg::REG_RADIUS_SQ: prdata = {30'd0, radius_sq};
      sni_pkg::REG_GAMMA:     prdata = {47'd0, gamma_value};
      sni_pkg::REG_PERIODIC:  prdata = {63'd0, periodic_mode};
      sni_pkg::REG_PERIOD_X:  prdata = {48'd0, period_x};
      sni_pkg::REG_PERIOD_Y:  prdata = {48'd0, period_y};
      default:                prdata = '0;
    endcase
  end

  // point store
  logic              accept;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic [10:0]       j;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (operation == sni_pkg::OP_WRITE)
                  && (32'(point_index) < 32'(MAX_POINTS));
  assign ram_raddr = RAM_AW'(j);

  sni_ram #(
    .WIDTH(32),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(RAM_AW'(point_index)),
    .wdata({pos_x, pos_y}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // query registers
  logic signed [15:0] qx;
  logic signed [15:0] qy;
  logic [9:0]         idx_q;
  logic               skip_q;
  logic [10:0]        n_q;
  logic [10:0]        n_sat;
  logic [15:0]        dx;
  logic [15:0]        dy;
  logic [31:0]        sqx;
  logic [31:0]        sqy;
  logic               use_pt;
  logic               last;
  logic [10:0]        count;
  logic [10:0]        k;
  logic [16:0]        acc;

  assign n_sat = (point_count > CNT_CAP) ? CNT_CAP : point_count;

  // per-axis distance
  logic signed [16:0] diff_x;
  logic signed [16:0] diff_y;
  logic [15:0]        ad_x;
  logic [15:0]        ad_y;
  logic [15:0]        alt_x;
  logic [15:0]        alt_y;
  logic [15:0]        dist_x;
  logic [15:0]        dist_y;

  always_comb begin
    diff_x = {qx[15], qx} - {ram_rdata[31], ram_rdata[31:16]};
    diff_y = {qy[15], qy} - {ram_rdata[15], ram_rdata[15:0]};
    ad_x   = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
    ad_y   = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
    alt_x  = (period_x >= ad_x) ? (period_x - ad_x) : (ad_x - period_x);
    alt_y  = (period_y >= ad_y) ? (period_y - ad_y) : (ad_y - period_y);
    dist_x = (periodic_mode && (alt_x < ad_x)) ? alt_x : ad_x;
    dist_y = (periodic_mode && (alt_y < ad_y)) ? alt_y : ad_y;
  end

  // shared multiplier
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] product;
  logic [17:0] pow_shift;
  logic [16:0] pow_next;
  logic [32:0] dist_sum;

  always_comb begin
    case (state)
      ST_SQX: begin
        mul_a = {1'b0, dx};
        mul_b = {1'b0, dx};
      end
      ST_SQY: begin
        mul_a = {1'b0, dy};
        mul_b = {1'b0, dy};
      end
      default: begin
        mul_a = acc;
        mul_b = gamma_value;
      end
    endcase
    product   = 34'(mul_a) * 34'(mul_b);
    pow_shift = product[33:16];
    pow_next  = (pow_shift > 18'(sni_pkg::INTENSITY_MAX)) ? sni_pkg::INTENSITY_MAX
                                                          : pow_shift[16:0];
    dist_sum  = {1'b0, sqx} + {1'b0, sqy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      j     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (operation == sni_pkg::OP_QUERY)) begin
            qx     <= pos_x;
            qy     <= pos_y;
            idx_q  <= point_index;
            skip_q <= skip_valid;
            n_q    <= n_sat;
            count  <= '0;
            j      <= '0;
            state  <= (n_sat == 11'd0) ? ST_PINIT : ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_DIST;
        end
        ST_DIST: begin
          dx     <= dist_x;
          dy     <= dist_y;
          use_pt <= !(skip_q && (j == {1'b0, idx_q}));
          last   <= ((j + 11'd1) == n_q);
          j      <= j + 11'd1;
          state  <= ST_SQX;
        end
        ST_SQX: begin
          sqx   <= product[31:0];
          state <= ST_SQY;
        end
        ST_SQY: begin
          sqy   <= product[31:0];
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (use_pt && ({1'b0, dist_sum} < radius_sq)) begin
            count <= count + 11'd1;
          end
          state <= last ? ST_PINIT : ST_DIST;
        end
        ST_PINIT: begin
          k     <= count;
          acc   <= sni_pkg::ONE_Q16;
          state <= ST_POW;
        end
        ST_POW: begin
          if (gamma_value == 17'd0) begin
            neighbour_count <= count;
            intensity       <= (count != 11'd0) ? 17'd0 : sni_pkg::ONE_Q16;
            done            <= 1'b1;
            state           <= ST_IDLE;
          end else if ((k == 11'd0) || (acc == 17'd0)) begin
            neighbour_count <= count;
            intensity       <= acc;
            done            <= 1'b1;
            state           <= ST_IDLE;
          end else begin
            acc <= pow_next;
            k   <= k - 11'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == sni_pkg::OP_QUERY)) |=> busy)
    else $error("query not started");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == sni_pkg::OP_WRITE)) |=> !busy && !done)
    else $error("write caused activity");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (neighbour_count <= n_q))
    else $error("neighbour count above points in use");
  a_zero_one: assert property (@(posedge clk) disable iff (rst)
    (done && (neighbour_count == 11'd0)) |-> (intensity == sni_pkg::ONE_Q16))
    else $error("empty neighbourhood intensity not one");
`endif

endmodule
